/* hdl/vrs_pkg.sv */
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared types, constants and the register map of the range sensor regs.
// ----------------------------------------------------------------------------
`default_nettype none

package vrs_pkg;

    localparam int unsigned REG_COUNT = 256;
    localparam int unsigned PTR_W     = $clog2(REG_COUNT);
    localparam int unsigned DIST_W    = 16;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 2'd3;

    // configuration reset values
    localparam logic [STEP_W-1:0] RST_STEP    = 8'd10;
    localparam logic [DIST_W-1:0] RST_CEILING = 16'd1000;
    localparam logic [DIST_W-1:0] RST_FLOOR   = 16'd100;
    localparam logic [DIST_W-1:0] RST_INIT    = 16'd500;

    // register map
    localparam logic [PTR_W-1:0] ADDR_START    = 8'h00;
    localparam logic [PTR_W-1:0] ADDR_STATUS   = 8'h13;
    localparam logic [PTR_W-1:0] ADDR_RANGE_HI = 8'h1E;
    localparam logic [PTR_W-1:0] ADDR_RANGE_LO = 8'h1F;
    localparam logic [PTR_W-1:0] ADDR_MODEL_ID = 8'hC0;
    localparam logic [PTR_W-1:0] ADDR_REVISION = 8'hC2;

    localparam logic [7:0] VAL_MODEL_ID = 8'hEE;
    localparam logic [7:0] VAL_REVISION = 8'h10;
    localparam logic [7:0] VAL_STATUS   = 8'h07;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec_write;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
    } t_dp_stat;

    // register store read: only the start byte and the range bytes ever change
    function automatic logic [7:0] reg_read(
        input logic [PTR_W-1:0]  addr,
        input logic [7:0]        start_byte,
        input logic [DIST_W-1:0] range_val
    );
        logic [7:0] val;
        case (addr)
            ADDR_START:    val = start_byte;
            ADDR_STATUS:   val = VAL_STATUS;
            ADDR_RANGE_HI: val = range_val[15:8];
            ADDR_RANGE_LO: val = range_val[7:0];
            ADDR_MODEL_ID: val = VAL_MODEL_ID;
            ADDR_REVISION: val = VAL_REVISION;
            default:       val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* hdl/vrs_ctrl.sv */
// ----------------------------------------------------------------------------
// vrs_ctrl
// Controller: input handshake, execute step and output slot tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_ctrl import vrs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_ready;
        o_ready     = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.is_read) begin
                    o_cmd.exec_write = 1'b1;
                    n_state          = ST_IDLE;
                end else if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/vrs_dp.sv */
// ----------------------------------------------------------------------------
// vrs_dp
// Datapath: config registers, pointer, start byte, distance and result.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_dp import vrs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_cmd_bit,
    input  wire logic [PTR_W-1:0]     i_pointer_byte,
    input  wire logic                 i_has_data,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [7:0]                o_read_data,
    output logic [PTR_W-1:0]          o_next_pointer
);

    // captured item
    logic             r_cmd;
    logic [PTR_W-1:0] r_ptr_in;
    logic             r_has_data;
    logic [7:0]       r_data;

    // state
    logic [STEP_W-1:0] r_step;
    logic [DIST_W-1:0] r_ceiling;
    logic [DIST_W-1:0] r_floor;
    logic [DIST_W-1:0] r_dist;
    logic [PTR_W-1:0]  r_ptr;
    logic [7:0]        r_start;

    // result
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_rd_ptr;

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] n_dist;
    logic [PTR_W-1:0]  ptr_inc;
    logic              start_wr;

    assign sum      = {1'b0, r_dist} + {{(DIST_W + 1 - STEP_W){1'b0}}, r_step};
    assign n_dist   = (sum > {1'b0, r_ceiling}) ? r_floor : sum[DIST_W-1:0];
    assign ptr_inc  = r_ptr + 1'b1;
    assign start_wr = (r_ptr_in == ADDR_START) && r_has_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= i_cmd_bit;
            r_ptr_in   <= i_pointer_byte;
            r_has_data <= i_has_data;
            r_data     <= i_data_byte;
        end
        if (i_cmd.load_out) begin
            r_rd_data <= reg_read(r_ptr, r_start, r_dist);
            r_rd_ptr  <= ptr_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= RST_STEP;
            r_ceiling <= RST_CEILING;
            r_floor   <= RST_FLOOR;
            r_dist    <= RST_INIT;
            r_ptr     <= '0;
            r_start   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP:    r_step    <= i_cfg_data[STEP_W-1:0];
                    CFG_CEILING: r_ceiling <= i_cfg_data;
                    CFG_FLOOR:   r_floor   <= i_cfg_data;
                    CFG_INIT:    r_dist    <= i_cfg_data;
                    default: begin
                        r_step <= r_step;
                    end
                endcase
            end
            if (i_cmd.exec_write) begin
                r_ptr <= r_ptr_in;
                if (start_wr) begin
                    r_start <= r_data;
                    if (r_data[0]) begin
                        r_dist <= n_dist;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_ptr <= ptr_inc;
            end
        end
    end

    assign o_stat.is_read = (r_cmd == CMD_READ);
    assign o_read_data    = r_rd_data;
    assign o_next_pointer = r_rd_ptr;

endmodule

`default_nettype wire

/* hdl/virtual_range_sensor_regs.sv */
// ----------------------------------------------------------------------------
// virtual_range_sensor_regs
// Emulated range sensor register file, one bus transaction per item.
//
// Input channel (i_valid/o_ready): one transaction per item. A write sets
// the register pointer; at index 0 an optional data byte is stored and
// bit 0 of it advances the simulated distance. A read returns the byte at
// the pointer and post-increments it.
// Output channel (o_valid/i_ready): one item per read, none per write.
// A read result is registered by the execute step that follows acceptance.
// The controller accepts a new item only after the execute step of the
// last one; a read's execute step holds while the output register is full.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data; writing initial_distance loads
// the distance. The user writes only while idle; this is not enforced.
// Reset (synchronous, active low): config defaults, pointer 0, distance
// 500, output empty. No clearing pass: fixed bytes come from a table.
// Receiver stall: the result waits in the output register; writes still run,
// and a read is accepted, then held in execute until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_range_sensor_regs import vrs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_cmd,
    input  wire logic [PTR_W-1:0]     i_pointer_byte,
    input  wire logic                 i_has_data,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_read_data,
    output logic [PTR_W-1:0]          o_next_pointer,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    vrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    vrs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cmd_bit      (i_cmd),
        .i_pointer_byte (i_pointer_byte),
        .i_has_data     (i_has_data),
        .i_data_byte    (i_data_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_read_data    (o_read_data),
        .o_next_pointer (o_next_pointer)
    );

endmodule

`default_nettype wire

/* hdl/vrs_checker.sv */
// ----------------------------------------------------------------------------
// vrs_checker
// Port-level checks of the range sensor regs, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_checker import vrs_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [7:0]       o_read_data,
    input wire logic [PTR_W-1:0] o_next_pointer
);

    // stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_read_data) && $stable(o_next_pointer))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted during execute step");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind virtual_range_sensor_regs vrs_checker u_vrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_read_data    (o_read_data),
    .o_next_pointer (o_next_pointer)
);

`default_nettype wire
